/* hw/rtl/trjc_pkg.sv */
`timescale 1ns / 1ps

package trjc_pkg;

    localparam int CoordW = 15;
    localparam int CoordBitsDefault = 15;
    localparam int PerimW = 16;
    localparam int DiaW = 16;
    localparam int CompW = 32;
    localparam int ThreshW = 16;
    localparam logic [ThreshW-1:0] ThreshReset = 16'd15;
    localparam int QueueDepth = 2;
    localparam int DivSteps = CompW;
    localparam int CntW = $clog2(DivSteps);
    localparam int MulW = 16;

    typedef struct packed {
        logic [CoordW-1:0] x_coord;
        logic [CoordW-1:0] y_coord;
        logic              last_point;
    } t_point;

    typedef struct packed {
        logic [CompW-1:0]  compactness;
        logic [PerimW-1:0] perimeter_sum;
        logic [DiaW-1:0]   max_diameter;
    } t_result;

    typedef enum logic {
        JOB_SINGLE,
        JOB_POINT
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic              last;
        logic [CoordW-1:0] seg_dx;
        logic [CoordW-1:0] seg_dy;
        logic [CoordW-1:0] dia_dx;
        logic [CoordW-1:0] dia_dy;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQ_X,
        BK_SQ_Y,
        BK_ROOT,
        BK_UPDATE,
        BK_PSQ,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

/* hw/rtl/trjc_queue.sv */
`timescale 1ns / 1ps

module trjc_queue import trjc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_push_job,
    input  logic      i_pop,
    output t_job      o_head,
    output t_q_status o_status
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CountW = $clog2(QueueDepth + 1);

    t_job              r_mem [QueueDepth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CountW-1:0] r_count;

    function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
        ptr_next = (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CountW'(QueueDepth));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

/* hw/rtl/trjc_front.sv */
`timescale 1ns / 1ps

module trjc_front import trjc_pkg::*; #(
    parameter int COORD_BITS = CoordBitsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_point    i_in_data,
    input  t_q_status i_q_status,
    output logic      o_in_stall,
    output logic      o_push,
    output t_job      o_push_job
);

    localparam logic [CoordW-1:0] CoordMask = CoordW'((1 << COORD_BITS) - 1);

    logic [CoordW-1:0] r_start_x;
    logic [CoordW-1:0] r_start_y;
    logic [CoordW-1:0] r_prior_x;
    logic [CoordW-1:0] r_prior_y;
    logic              r_have_point;

    logic              w_accept;
    logic [CoordW-1:0] w_x;
    logic [CoordW-1:0] w_y;

    function automatic logic [CoordW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                   input logic [CoordW-1:0] b);
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

    assign o_in_stall = i_q_status.full;
    assign w_accept   = i_in_valid && !i_q_status.full;
    assign w_x        = i_in_data.x_coord & CoordMask;
    assign w_y        = i_in_data.y_coord & CoordMask;

    // A first point that is also the last one closes a run with a zero result.
    assign o_push = w_accept && (r_have_point || i_in_data.last_point);

    always_comb begin
        o_push_job.kind   = r_have_point ? JOB_POINT : JOB_SINGLE;
        o_push_job.last   = i_in_data.last_point;
        o_push_job.seg_dx = abs_diff(r_prior_x, w_x);
        o_push_job.seg_dy = abs_diff(r_prior_y, w_y);
        o_push_job.dia_dx = abs_diff(r_start_x, w_x);
        o_push_job.dia_dy = abs_diff(r_start_y, w_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_point <= 1'b0;
        end else if (w_accept) begin
            r_have_point <= !i_in_data.last_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prior_x <= w_x;
            r_prior_y <= w_y;
            if (!r_have_point) begin
                r_start_x <= w_x;
                r_start_y <= w_y;
            end
        end
    end

endmodule

/* hw/rtl/trjc_back.sv */
`timescale 1ns / 1ps

module trjc_back import trjc_pkg::*; #(
    parameter int COORD_BITS = CoordBitsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [ThreshW-1:0] i_threshold,
    input  t_job               i_head,
    input  t_q_status          i_q_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_result            o_out_data
);

    localparam int RootBits = COORD_BITS + 1;
    localparam int RadBits = 2 * RootBits;
    localparam int RemBits = RootBits + 3;
    localparam int DivW = DiaW + 1;
    localparam int DremW = DivW + 1;

    t_back_state r_state;
    t_back_state n_state;

    t_job                 r_job;
    logic                 r_phase;
    logic [RadBits-1:0]   r_rad;
    logic [RemBits-1:0]   r_rem;
    logic [RootBits-1:0]  r_root;
    logic [CntW-1:0]      r_cnt;
    logic [PerimW-1:0]    r_perim;
    logic [DiaW-1:0]      r_dia;
    logic [CompW-1:0]     r_dvd;
    logic [DremW-1:0]     r_drem;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 w_slot_free;
    logic                 w_load;
    logic [MulW-1:0]      w_mul_a;
    logic [2*MulW-1:0]    w_prod;
    logic [RemBits-1:0]   w_rem_sh;
    logic [RemBits-1:0]   w_trial;
    logic                 w_root_bit;
    logic [DiaW-1:0]      w_root16;
    logic [DivW-1:0]      w_divisor;
    logic [DremW-1:0]     w_drem_sh;
    logic                 w_q_bit;

    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (r_state)
            BK_SQ_X:  w_mul_a = MulW'(r_phase ? r_job.dia_dx : r_job.seg_dx);
            BK_SQ_Y:  w_mul_a = MulW'(r_phase ? r_job.dia_dy : r_job.seg_dy);
            default:  w_mul_a = MulW'(r_perim);
        endcase
    end

    assign w_prod = w_mul_a * w_mul_a;

    assign w_rem_sh   = {r_rem[RemBits-3:0], r_rad[RadBits-1 -: 2]};
    assign w_trial    = {1'b0, r_root, 2'b01};
    assign w_root_bit = (w_rem_sh >= w_trial);
    assign w_root16   = DiaW'(r_root);

    assign w_divisor = {1'b0, r_dia} + 1'b1;
    assign w_drem_sh = {r_drem[DremW-2:0], r_dvd[CompW-1]};
    assign w_q_bit   = (w_drem_sh >= DremW'(w_divisor));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = (i_head.kind == JOB_SINGLE) ? BK_OUT : BK_SQ_X;
                end
            end
            BK_SQ_X: n_state = BK_SQ_Y;
            BK_SQ_Y: n_state = BK_ROOT;
            BK_ROOT: begin
                if (r_cnt == CntW'(RootBits - 1)) begin
                    n_state = BK_UPDATE;
                end
            end
            BK_UPDATE: begin
                if (!r_phase) begin
                    n_state = BK_SQ_X;
                end else begin
                    n_state = r_job.last ? BK_PSQ : BK_IDLE;
                end
            end
            BK_PSQ: n_state = BK_DIV;
            BK_DIV: begin
                if (r_cnt == CntW'(DivSteps - 1)) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (w_slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == BK_IDLE) && !i_q_status.empty;
        w_load = (r_state == BK_OUT) && w_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_perim     <= '0;
            r_dia       <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == BK_UPDATE) begin
                if (!r_phase) begin
                    if (w_root16 > i_threshold) begin
                        r_perim <= r_perim + w_root16;
                    end
                end else if (w_root16 > r_dia) begin
                    r_dia <= w_root16;
                end
            end
            if (w_load) begin
                r_perim <= '0;
                r_dia   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                if (o_pop) begin
                    r_job   <= i_head;
                    r_phase <= 1'b0;
                    r_dvd   <= '0;
                end
            end
            BK_SQ_X: r_rad <= RadBits'(w_prod);
            BK_SQ_Y: begin
                r_rad  <= r_rad + RadBits'(w_prod);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            BK_ROOT: begin
                r_rad  <= {r_rad[RadBits-3:0], 2'b00};
                r_rem  <= w_root_bit ? w_rem_sh - w_trial : w_rem_sh;
                r_root <= {r_root[RootBits-2:0], w_root_bit};
                r_cnt  <= r_cnt + 1'b1;
            end
            BK_UPDATE: r_phase <= 1'b1;
            BK_PSQ: begin
                r_dvd  <= CompW'(w_prod);
                r_drem <= '0;
                r_cnt  <= '0;
            end
            BK_DIV: begin
                r_dvd  <= {r_dvd[CompW-2:0], w_q_bit};
                r_drem <= w_q_bit ? w_drem_sh - DremW'(w_divisor) : w_drem_sh;
                r_cnt  <= r_cnt + 1'b1;
            end
            BK_OUT: begin
                if (w_load) begin
                    r_out.compactness   <= r_dvd;
                    r_out.perimeter_sum <= r_perim;
                    r_out.max_diameter  <= r_dia;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/trajectory_compactness.sv */
`timescale 1ns / 1ps

// Streams 2D trajectory points and, on the point marked last, reports the thresholded
// perimeter, the greatest distance from the first point and perimeter squared over
// (diameter + 1). The front stage accepts a point while the queue is not full and
// queues up to two points; the back stage runs one shared 16-bit multiplier, a
// one-bit-per-cycle square root and a one-bit-per-cycle divider. Each point after the
// first has its segment, then its diameter, squared, rooted and folded in; the last
// point adds the squaring of the perimeter and the 32-step division.
module trajectory_compactness import trjc_pkg::*; #(
    parameter int COORD_BITS = CoordBitsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ThreshW-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_point             i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_result            o_out_data
);

    logic [ThreshW-1:0] r_threshold;
    logic               w_push;
    t_job               w_push_job;
    logic               w_pop;
    t_job               w_head;
    t_q_status          w_q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ThreshReset;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    trjc_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_status (w_q_status),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_push_job (w_push_job)
    );

    trjc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_status   (w_q_status)
    );

    trjc_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_head      (w_head),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("Queue written while full.");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("Queue read while empty.");

    a_zero_diameter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.max_diameter == '0) |->
        (o_out_data.compactness ==
         CompW'(o_out_data.perimeter_sum) * CompW'(o_out_data.perimeter_sum)))
        else $error("Compactness differs from perimeter squared at zero diameter.");

    a_compact_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        (o_out_data.compactness <=
         CompW'(o_out_data.perimeter_sum) * CompW'(o_out_data.perimeter_sum)))
        else $error("Compactness exceeds perimeter squared.");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import trjc_pkg::*;

    localparam int CycleLimit = 1_000_000;
    localparam int SettleCycles = 200;
    localparam int HoldOffCycles = 3000;
    localparam int RandomPoints = 1950;
    localparam int PhaseCount = 6;
    localparam int CoordMax = (1 << CoordW) - 1;
    localparam int ReportCap = 100;

    class compactness_scoreboard;
        logic [ThreshW-1:0] threshold;
        logic [CoordW-1:0]  first_x, first_y, prev_x, prev_y;
        bit                 run_open;
        logic [PerimW-1:0]  perim;
        logic [DiaW-1:0]    diam;
        t_result            expected_q[$];
        int                 errors;

        function new();
            threshold = ThreshReset;
            errors = 0;
            close_run();
        endfunction

        function void close_run();
            first_x = '0;
            first_y = '0;
            prev_x = '0;
            prev_y = '0;
            run_open = 1'b0;
            perim = '0;
            diam = '0;
        endfunction

        function logic [15:0] floor_root(logic [31:0] v);
            logic [31:0] root, trial;
            root = '0;
            for (int b = 15; b >= 0; b--) begin
                trial = root | (32'd1 << b);
                if (trial * trial <= v) begin
                    root = trial;
                end
            end
            return root[15:0];
        endfunction

        function logic [15:0] distance(logic [CoordW-1:0] ax, logic [CoordW-1:0] ay,
                                       logic [CoordW-1:0] bx, logic [CoordW-1:0] by);
            logic [31:0] dx, dy;
            dx = (ax > bx) ? 32'(ax - bx) : 32'(bx - ax);
            dy = (ay > by) ? 32'(ay - by) : 32'(by - ay);
            return floor_root(dx * dx + dy * dy);
        endfunction

        function void note_point(t_point p);
            logic [15:0] seg, dia;
            t_result     r;
            if (!run_open) begin
                if (p.last_point) begin
                    r = '0;
                    expected_q.push_back(r);
                    close_run();
                end else begin
                    first_x = p.x_coord;
                    first_y = p.y_coord;
                    prev_x = p.x_coord;
                    prev_y = p.y_coord;
                    run_open = 1'b1;
                    perim = '0;
                    diam = '0;
                end
                return;
            end
            seg = distance(prev_x, prev_y, p.x_coord, p.y_coord);
            dia = distance(first_x, first_y, p.x_coord, p.y_coord);
            if (seg > threshold) begin
                perim = perim + seg;
            end
            if (dia > diam) begin
                diam = dia;
            end
            prev_x = p.x_coord;
            prev_y = p.y_coord;
            if (p.last_point) begin
                r.compactness = (32'(perim) * 32'(perim)) / (32'(diam) + 32'd1);
                r.perimeter_sum = perim;
                r.max_diameter = diam;
                expected_q.push_back(r);
                close_run();
            end
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            errors++;
            if (errors <= ReportCap) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= ReportCap) begin
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                             $time, got.compactness, got.perimeter_sum, got.max_diameter);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.compactness !== want.compactness) begin
                report("compactness", want.compactness, got.compactness);
            end
            if (got.perimeter_sum !== want.perimeter_sum) begin
                report("perimeter_sum", want.perimeter_sum, got.perimeter_sum);
            end
            if (got.max_diameter !== want.max_diameter) begin
                report("max_diameter", want.max_diameter, got.max_diameter);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [ThreshW-1:0] i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    t_point             i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_result            o_out_data;

    compactness_scoreboard board = new();
    bit                    hold_req = 1'b0;
    bit                    hold_done = 1'b0;
    bit                    offering = 1'b0;
    int                    burst_left = 0;
    int                    cur_x = 0;
    int                    cur_y = 0;
    int unsigned           cycle_count = 0;

    trajectory_compactness dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("trajectory_compactness regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_result(o_out_data);
        end
    end

    // The receiver alternates between free-flowing, random and mostly-stalled stretches.
    initial begin
        int mode, len;
        i_out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(20, 400);
            repeat (len) begin
                @(posedge i_clk);
                if (hold_req && !hold_done) begin
                    i_out_stall <= 1'b1;
                    repeat (HoldOffCycles) @(posedge i_clk);
                    hold_done = 1'b1;
                end else begin
                    case (mode)
                        0: begin
                            i_out_stall <= 1'b0;
                        end
                        1: begin
                            i_out_stall <= 1'($urandom_range(0, 1));
                        end
                        default: begin
                            i_out_stall <= ($urandom_range(0, 7) != 0);
                        end
                    endcase
                end
            end
        end
    end

    function automatic t_point pt(int x, int y, bit last);
        t_point p;
        p.x_coord = CoordW'(x);
        p.y_coord = CoordW'(y);
        p.last_point = last;
        return p;
    endfunction

    function automatic int clip(int v);
        if (v < 0) begin
            return 0;
        end
        if (v > CoordMax) begin
            return CoordMax;
        end
        return v;
    endfunction

    function automatic t_point make_point(bit last);
        int span;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                span = 4 << (2 * $urandom_range(0, 2));
                cur_x = clip(cur_x + int'($urandom_range(0, 2 * span)) - span);
                cur_y = clip(cur_y + int'($urandom_range(0, 2 * span)) - span);
            end
            4, 5, 6: begin
                cur_x = $urandom_range(0, CoordMax);
                cur_y = $urandom_range(0, CoordMax);
            end
            7: begin
                cur_x = $urandom_range(0, 1) ? CoordMax : 0;
                cur_y = $urandom_range(0, 1) ? CoordMax : 0;
            end
            default: begin
            end
        endcase
        return pt(cur_x, cur_y, last);
    endfunction

    task automatic lower_valid();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_point(t_point p);
        i_in_valid <= 1'b1;
        i_in_data <= p;
        offering = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        board.note_point(p);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            lower_valid();
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(9, 60) : $urandom_range(1, 8))
                @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic settle();
        lower_valid();
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [ThreshW-1:0] value);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.threshold = value;
    endtask

    initial begin
        int                 len, sent;
        logic [ThreshW-1:0] thr;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_point(pt(100, 200, 1));
        send_point(pt(0, 0, 0));
        send_point(pt(CoordMax, CoordMax, 1));
        send_point(pt(1000, 1000, 0));
        send_point(pt(1015, 1000, 0));
        send_point(pt(1031, 1000, 1));
        send_point(pt(0, 0, 0));
        send_point(pt(CoordMax, CoordMax, 0));
        send_point(pt(0, 0, 0));
        send_point(pt(CoordMax, CoordMax, 1));
        send_point(pt(CoordMax, 0, 0));
        send_point(pt(0, CoordMax, 0));
        send_point(pt(CoordMax, 0, 1));
        send_point(pt(CoordMax, 0, 1));
        write_threshold('0);
        send_point(pt(5, 5, 0));
        send_point(pt(5, 6, 0));
        send_point(pt(5, 6, 0));
        send_point(pt(6, 6, 1));
        write_threshold('1);
        send_point(pt(0, 0, 0));
        send_point(pt(CoordMax, CoordMax, 1));

        for (int ph = 0; ph < PhaseCount; ph++) begin
            case (ph)
                0: thr = ThreshReset;
                1: thr = '0;
                2: thr = '1;
                4: thr = ThreshW'($urandom_range(0, 65535));
                default: thr = ThreshW'($urandom_range(0, 80));
            endcase
            write_threshold(thr);
            // The receiver holds off for a long stretch so the block backs up.
            if (ph == 3) begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < RandomPoints / PhaseCount) begin
                len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 40);
                for (int k = 0; k < len; k++) begin
                    send_point(make_point(k == len - 1));
                end
                sent += len;
            end
        end

        settle();
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("trajectory_compactness regression: pass");
        end else begin
            $display("trajectory_compactness regression: fail");
        end
        $finish;
    end

endmodule
